>>> hw/rtl/clns_pkg.sv
package clns_pkg;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic       line_select;
    logic [2:0] glyph_slot;
    logic [2:0] glyph_row;
  } in_word_t;

  typedef struct packed {
    logic        register_select;
    logic [3:0]  nibble;
    logic [13:0] wait_before_us;
    logic [8:0]  pulse_us;
    logic [12:0] wait_after_us;
    logic        last;
  } out_word_t;

  localparam logic [2:0] OP_COMMAND   = 3'd0;
  localparam logic [2:0] OP_DATA      = 3'd1;
  localparam logic [2:0] OP_CURSOR    = 3'd2;
  localparam logic [2:0] OP_INIT      = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_GLYPH_ROW = 3'd5;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_SET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_MODE   = 2'd2;

  localparam logic [7:0] RST_FUNCTION_SET = 8'h28;
  localparam logic [7:0] RST_DISPLAY_MODE = 8'h0C;
  localparam logic [7:0] RST_ENTRY_MODE   = 8'h06;

  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_SET_CGRAM = 8'h40;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  localparam logic [2:0] GLYPH_FIRST_ROW = 3'd0;
  localparam logic [2:0] GLYPH_LAST_ROW  = 3'd7;

  localparam logic [3:0]  NIB_INIT_FIRST   = 4'h3;
  localparam logic [3:0]  NIB_INIT_SECOND  = 4'h2;
  localparam logic [13:0] T_INIT_BEFORE    = 14'd15000;
  localparam logic [8:0]  T_INIT_PULSE     = 9'd10;
  localparam logic [12:0] T_INIT_AFTER_1ST = 13'd4100;
  localparam logic [12:0] T_INIT_AFTER_2ND = 13'd1000;
  localparam logic [13:0] T_BYTE_BEFORE    = 14'd500;
  localparam logic [8:0]  T_BYTE_PULSE     = 9'd500;
  localparam logic [12:0] T_CLEAR_AFTER    = 13'd5000;

  localparam int MAX_JOBS  = 4;
  localparam int JOB_IDX_W = 2;
  localparam int STEP_W    = 4;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic       clr_wait;
  } byte_job_t;

  typedef struct packed {
    logic                      prefix;
    logic [JOB_IDX_W-1:0]      last_job;
    byte_job_t [MAX_JOBS-1:0]  jobs;
  } desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  function automatic byte_job_t make_job(logic rs, logic [7:0] value, logic clr_wait);
    byte_job_t j;
    j.rs       = rs;
    j.value    = value;
    j.clr_wait = clr_wait;
    return j;
  endfunction

endpackage

>>> hw/rtl/clns_front.sv
module clns_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  clns_pkg::in_word_t             in_word,
  output logic                           busy,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [clns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  clns_pkg::queue_status_t        qstat,
  output logic                           push,
  output clns_pkg::desc_t                push_desc
);

  logic [7:0] fs_r, fs_nxt;
  logic [7:0] dm_r, dm_nxt;
  logic [7:0] em_r, em_nxt;
  logic       cfg_we;
  logic       op_known;
  logic [clns_pkg::JOB_IDX_W-1:0] gidx;
  clns_pkg::desc_t d;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_comb begin
    fs_nxt = fs_r;
    dm_nxt = dm_r;
    em_nxt = em_r;
    if (cfg_we) begin
      case (cfg_index)
        clns_pkg::CFG_FUNCTION_SET: fs_nxt = cfg_data;
        clns_pkg::CFG_DISPLAY_MODE: dm_nxt = cfg_data;
        clns_pkg::CFG_ENTRY_MODE:   em_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= clns_pkg::RST_FUNCTION_SET;
      dm_r <= clns_pkg::RST_DISPLAY_MODE;
      em_r <= clns_pkg::RST_ENTRY_MODE;
    end else begin
      fs_r <= fs_nxt;
      dm_r <= dm_nxt;
      em_r <= em_nxt;
    end
  end

  always_comb begin
    d        = '0;
    op_known = 1'b1;
    gidx     = '0;
    case (in_word.operation)
      clns_pkg::OP_COMMAND: begin
        d.jobs[0] = clns_pkg::make_job(1'b0, in_word.byte_value, 1'b0);
      end
      clns_pkg::OP_DATA: begin
        d.jobs[0] = clns_pkg::make_job(1'b1, in_word.byte_value, 1'b0);
      end
      clns_pkg::OP_CURSOR: begin
        d.jobs[0] = clns_pkg::make_job(1'b0,
            clns_pkg::CMD_SET_DDRAM + {1'b0, in_word.line_select, 6'b0}
                                    + {2'b0, in_word.column}, 1'b0);
      end
      clns_pkg::OP_INIT: begin
        d.prefix   = 1'b1;
        d.last_job = 2'd3;
        d.jobs[0]  = clns_pkg::make_job(1'b0, fs_r, 1'b0);
        d.jobs[1]  = clns_pkg::make_job(1'b0, dm_r, 1'b0);
        d.jobs[2]  = clns_pkg::make_job(1'b0, em_r, 1'b0);
        d.jobs[3]  = clns_pkg::make_job(1'b0, clns_pkg::CMD_CLEAR, 1'b1);
      end
      clns_pkg::OP_CLEAR: begin
        d.jobs[0] = clns_pkg::make_job(1'b0, clns_pkg::CMD_CLEAR, 1'b1);
      end
      clns_pkg::OP_GLYPH_ROW: begin
        if (in_word.glyph_row == clns_pkg::GLYPH_FIRST_ROW) begin
          d.jobs[0] = clns_pkg::make_job(1'b0,
              clns_pkg::CMD_SET_CGRAM + {2'b0, in_word.glyph_slot, 3'b0}, 1'b0);
          d.jobs[1] = clns_pkg::make_job(1'b1, in_word.byte_value, 1'b0);
          gidx      = 2'd1;
        end else begin
          d.jobs[0] = clns_pkg::make_job(1'b1, in_word.byte_value, 1'b0);
        end
        if (in_word.glyph_row == clns_pkg::GLYPH_LAST_ROW) begin
          gidx          = gidx + 2'd1;
          d.jobs[gidx]  = clns_pkg::make_job(1'b0, clns_pkg::CMD_HOME, 1'b0);
        end
        d.last_job = gidx;
      end
      default: begin
        op_known = 1'b0;
      end
    endcase
  end

  assign busy      = qstat.full;
  assign push      = start & ~busy & op_known;
  assign push_desc = d;

endmodule

>>> hw/rtl/clns_queue.sv
module clns_queue #(
  parameter int DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  clns_pkg::desc_t         push_desc,
  input  logic                    pop,
  output clns_pkg::desc_t         head,
  output clns_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  clns_pkg::desc_t  slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head         = slots_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CNT_FULL);

endmodule

>>> hw/rtl/clns_back.sv
module clns_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  clns_pkg::desc_t         head,
  input  clns_pkg::queue_status_t qstat,
  output logic                    pop,
  output logic                    out_strobe,
  output clns_pkg::out_word_t     out_word
);

  logic [clns_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [clns_pkg::STEP_W-1:0] last_step;
  logic [clns_pkg::STEP_W-1:0] job_step;
  logic                        in_prefix;
  logic                        active;
  logic                        is_last;
  clns_pkg::byte_job_t         job;
  clns_pkg::out_word_t         strobe;
  logic                        out_strobe_r;
  clns_pkg::out_word_t         out_word_r;

  assign active    = ~qstat.empty;
  assign last_step = (head.prefix ? 4'd2 : 4'd0) + {1'b0, head.last_job, 1'b1};
  assign job_step  = step_r - (head.prefix ? 4'd2 : 4'd0);
  assign in_prefix = head.prefix & (step_r[3:1] == 3'd0);
  assign job       = head.jobs[job_step[2:1]];
  assign is_last   = (step_r == last_step);
  assign pop       = active & is_last;

  always_comb begin
    strobe = '0;
    if (in_prefix) begin
      strobe.register_select = 1'b0;
      strobe.pulse_us        = clns_pkg::T_INIT_PULSE;
      if (step_r[0] == 1'b0) begin
        strobe.nibble         = clns_pkg::NIB_INIT_FIRST;
        strobe.wait_before_us = clns_pkg::T_INIT_BEFORE;
        strobe.wait_after_us  = clns_pkg::T_INIT_AFTER_1ST;
      end else begin
        strobe.nibble         = clns_pkg::NIB_INIT_SECOND;
        strobe.wait_after_us  = clns_pkg::T_INIT_AFTER_2ND;
      end
    end else begin
      strobe.register_select = job.rs;
      strobe.pulse_us        = clns_pkg::T_BYTE_PULSE;
      if (job_step[0] == 1'b0) begin
        strobe.nibble         = job.value[7:4];
        strobe.wait_before_us = clns_pkg::T_BYTE_BEFORE;
      end else begin
        strobe.nibble        = job.value[3:0];
        strobe.wait_after_us = job.clr_wait ? clns_pkg::T_CLEAR_AFTER : 13'd0;
      end
    end
    strobe.last = is_last;
  end

  always_comb begin
    step_nxt = step_r;
    if (active) begin
      step_nxt = is_last ? '0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      step_r       <= step_nxt;
      out_strobe_r <= active;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= strobe;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

>>> hw/rtl/char_lcd_nibble_sequencer_unit.sv
// Channel  Ports                                   Handshake
// request  start, busy, in_word                    taken when start is high and busy is low
// strobe   out_strobe, out_word                    one word per cycle, cannot be held off
// config   cfg_valid, cfg_ready, cfg_index, cfg_data  written when valid and ready are high
//
// The back sequencer emits one strobe word per cycle: a command, data, cursor or clear request
// is 2 strobe words, a glyph row 2 to 4 and an initialization 10.
// On an idle sequencer a taken request is first written to the queue; its first word is then
// formed from the queue head and registered before it is on the strobe ports.
// A queue of QUEUE_DEPTH requests lets new requests be taken while earlier ones are sent.
// Reset is synchronous and clears the queue, the sequencer and the set-up registers.
// busy is high only while the queue is full; the strobe side never stalls.
module char_lcd_nibble_sequencer_unit #(
  parameter int QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  clns_pkg::in_word_t             in_word,
  output logic                           out_strobe,
  output clns_pkg::out_word_t            out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [clns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  logic                    push;
  logic                    pop;
  clns_pkg::desc_t         push_desc;
  clns_pkg::desc_t         head;
  clns_pkg::queue_status_t qstat;

  clns_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .push_desc (push_desc)
  );

  clns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .status    (qstat)
  );

  clns_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

>>> hw/rtl/clns_checker.sv
module clns_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_strobe,
  input clns_pkg::out_word_t out_word,
  input logic                cfg_ready
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe word right after reset");

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
      (out_strobe && !out_word.last) |=> out_strobe)
    else $error("gap inside the strobe run of one request");

  a_init_pair: assert property (@(posedge clk) disable iff (!rst_n)
      (out_strobe && out_word.wait_before_us == clns_pkg::T_INIT_BEFORE) |=>
      (out_strobe && out_word.nibble == clns_pkg::NIB_INIT_SECOND &&
       out_word.wait_after_us == clns_pkg::T_INIT_AFTER_2ND))
    else $error("initialization nibble pair broken");

  a_high_half_not_last: assert property (@(posedge clk) disable iff (!rst_n)
      (out_strobe && out_word.wait_before_us == clns_pkg::T_BYTE_BEFORE) |-> !out_word.last)
    else $error("request ends on the high nibble of a byte");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind char_lcd_nibble_sequencer_unit clns_checker u_clns_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_word   (out_word),
  .cfg_ready  (cfg_ready)
);

>>> verif/char_lcd_nibble_sequencer_unit_test.sv
module char_lcd_nibble_sequencer_unit_test;

  localparam logic [2:0] OP_UNDEF_LOW = 3'd6;
  localparam logic [2:0] OP_UNDEF_HIGH = 3'd7;
  localparam logic [clns_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [7:0] LINE2_BASE = 8'h40;
  localparam int RANDOM_WORDS = 240;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  clns_pkg::in_word_t in_word = '0;
  logic out_strobe;
  clns_pkg::out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [clns_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  logic [7:0] model_function_set;
  logic [7:0] model_display_mode;
  logic [7:0] model_entry_mode;
  clns_pkg::out_word_t pending_strobes[$];
  clns_pkg::out_word_t burst_buf[10];
  int burst_len;
  int error_count = 0;
  int cycle_count = 0;
  bit no_gaps = 1'b0;

  char_lcd_nibble_sequencer_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .out_strobe(out_strobe),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic void add_strobe(input logic rs, input logic [3:0] nib,
                                     input logic [13:0] before_us, input logic [8:0] pulse,
                                     input logic [12:0] after_us);
    clns_pkg::out_word_t s;
    s.register_select = rs;
    s.nibble = nib;
    s.wait_before_us = before_us;
    s.pulse_us = pulse;
    s.wait_after_us = after_us;
    s.last = 1'b0;
    burst_buf[burst_len] = s;
    burst_len++;
  endfunction

  function automatic void add_byte(input logic rs, input logic [7:0] value,
                                   input logic [12:0] after_us);
    add_strobe(rs, value[7:4], clns_pkg::T_BYTE_BEFORE, clns_pkg::T_BYTE_PULSE, '0);
    add_strobe(rs, value[3:0], '0, clns_pkg::T_BYTE_PULSE, after_us);
  endfunction

  function automatic void expand_request(input clns_pkg::in_word_t w);
    clns_pkg::out_word_t s;
    logic [7:0] addr;
    burst_len = 0;
    case (w.operation)
      clns_pkg::OP_COMMAND: add_byte(1'b0, w.byte_value, '0);
      clns_pkg::OP_DATA: add_byte(1'b1, w.byte_value, '0);
      clns_pkg::OP_CURSOR: begin
        addr = clns_pkg::CMD_SET_DDRAM + (w.line_select ? LINE2_BASE : 8'h00)
               + {2'b00, w.column};
        add_byte(1'b0, addr, '0);
      end
      clns_pkg::OP_INIT: begin
        add_strobe(1'b0, clns_pkg::NIB_INIT_FIRST, clns_pkg::T_INIT_BEFORE,
                   clns_pkg::T_INIT_PULSE, clns_pkg::T_INIT_AFTER_1ST);
        add_strobe(1'b0, clns_pkg::NIB_INIT_SECOND, '0, clns_pkg::T_INIT_PULSE,
                   clns_pkg::T_INIT_AFTER_2ND);
        add_byte(1'b0, model_function_set, '0);
        add_byte(1'b0, model_display_mode, '0);
        add_byte(1'b0, model_entry_mode, '0);
        add_byte(1'b0, clns_pkg::CMD_CLEAR, clns_pkg::T_CLEAR_AFTER);
      end
      clns_pkg::OP_CLEAR: add_byte(1'b0, clns_pkg::CMD_CLEAR, clns_pkg::T_CLEAR_AFTER);
      clns_pkg::OP_GLYPH_ROW: begin
        if (w.glyph_row == clns_pkg::GLYPH_FIRST_ROW) begin
          add_byte(1'b0, clns_pkg::CMD_SET_CGRAM + {2'b00, w.glyph_slot, 3'b000}, '0);
        end
        add_byte(1'b1, w.byte_value, '0);
        if (w.glyph_row == clns_pkg::GLYPH_LAST_ROW) begin
          add_byte(1'b0, clns_pkg::CMD_HOME, '0);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < burst_len; i++) begin
      s = burst_buf[i];
      s.last = (i == burst_len - 1);
      pending_strobes.push_back(s);
    end
  endfunction

  always @(posedge clk) begin : strobe_monitor
    clns_pkg::out_word_t want;
    if (!rst_n) begin
      model_function_set <= clns_pkg::RST_FUNCTION_SET;
      model_display_mode <= clns_pkg::RST_DISPLAY_MODE;
      model_entry_mode <= clns_pkg::RST_ENTRY_MODE;
    end else begin
      if (out_strobe) begin
        if (pending_strobes.size() == 0) begin
          report_mismatch("strobe word with nothing expected");
        end else begin
          want = pending_strobes.pop_front();
          if (out_word.register_select !== want.register_select)
            report_mismatch($sformatf("register_select got %0d want %0d",
                                      out_word.register_select, want.register_select));
          if (out_word.nibble !== want.nibble)
            report_mismatch($sformatf("nibble got %0h want %0h", out_word.nibble, want.nibble));
          if (out_word.wait_before_us !== want.wait_before_us)
            report_mismatch($sformatf("wait_before_us got %0d want %0d",
                                      out_word.wait_before_us, want.wait_before_us));
          if (out_word.pulse_us !== want.pulse_us)
            report_mismatch($sformatf("pulse_us got %0d want %0d",
                                      out_word.pulse_us, want.pulse_us));
          if (out_word.wait_after_us !== want.wait_after_us)
            report_mismatch($sformatf("wait_after_us got %0d want %0d",
                                      out_word.wait_after_us, want.wait_after_us));
          if (out_word.last !== want.last)
            report_mismatch($sformatf("last got %0d want %0d", out_word.last, want.last));
        end
      end
      if (start && !busy) begin
        expand_request(in_word);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          clns_pkg::CFG_FUNCTION_SET: model_function_set <= cfg_data;
          clns_pkg::CFG_DISPLAY_MODE: model_display_mode <= cfg_data;
          clns_pkg::CFG_ENTRY_MODE: model_entry_mode <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  function automatic clns_pkg::in_word_t random_word(input logic [2:0] op);
    clns_pkg::in_word_t w;
    w.operation = op;
    w.byte_value = 8'($urandom_range(0, 255));
    w.column = 6'($urandom_range(0, 63));
    w.line_select = 1'($urandom_range(0, 1));
    w.glyph_slot = 3'($urandom_range(0, 7));
    w.glyph_row = 3'($urandom_range(0, 7));
    return w;
  endfunction

  task automatic send_word(input clns_pkg::in_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 15) == 0) begin
      no_gaps = ~no_gaps;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_strobes();
    start <= 1'b0;
    while (pending_strobes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [clns_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
    int gap;
    gap = $urandom_range(0, 14);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_setup(input logic [7:0] fs, input logic [7:0] dm, input logic [7:0] em);
    drain_strobes();
    write_reg(clns_pkg::CFG_FUNCTION_SET, fs);
    write_reg(clns_pkg::CFG_DISPLAY_MODE, dm);
    write_reg(clns_pkg::CFG_ENTRY_MODE, em);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_setup();
    send_word(random_word(clns_pkg::OP_INIT));
    drain_strobes();
  endtask

  task automatic test_directed_requests();
    clns_pkg::in_word_t w;
    w = '0;
    w.operation = clns_pkg::OP_COMMAND;
    send_word(w);
    w.byte_value = 8'hFF;
    send_word(w);
    w.operation = clns_pkg::OP_DATA;
    w.byte_value = 8'h00;
    send_word(w);
    w.byte_value = 8'hFF;
    send_word(w);
    w.byte_value = 8'hA5;
    send_word(w);
    w = '0;
    w.operation = clns_pkg::OP_CURSOR;
    send_word(w);
    w.line_select = 1'b1;
    w.column = 6'd39;
    send_word(w);
    w.column = 6'd63;
    send_word(w);
    w.line_select = 1'b0;
    send_word(w);
    w = '0;
    w.operation = clns_pkg::OP_CLEAR;
    send_word(w);
    w = '0;
    w.operation = clns_pkg::OP_GLYPH_ROW;
    w.glyph_row = clns_pkg::GLYPH_FIRST_ROW;
    w.byte_value = 8'h1F;
    send_word(w);
    w.glyph_slot = 3'd7;
    w.byte_value = 8'hFF;
    send_word(w);
    w.glyph_row = 3'd3;
    w.byte_value = 8'h00;
    send_word(w);
    w.glyph_row = clns_pkg::GLYPH_LAST_ROW;
    w.byte_value = 8'h0E;
    send_word(w);
    w.glyph_slot = 3'd0;
    send_word(w);
    w = '1;
    w.operation = OP_UNDEF_LOW;
    send_word(w);
    w.operation = OP_UNDEF_HIGH;
    send_word(w);
    w = '0;
    w.operation = OP_UNDEF_HIGH;
    send_word(w);
    send_word(random_word(clns_pkg::OP_INIT));
    drain_strobes();
  endtask

  task automatic test_setup_registers();
    write_setup(8'h00, 8'h00, 8'h00);
    send_word(random_word(clns_pkg::OP_INIT));
    send_word(random_word(clns_pkg::OP_CLEAR));
    write_setup(8'hFF, 8'hFF, 8'hFF);
    send_word(random_word(clns_pkg::OP_INIT));
    send_word(random_word(clns_pkg::OP_INIT));
    drain_strobes();
    write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_word(random_word(clns_pkg::OP_INIT));
    write_setup(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    send_word(random_word(clns_pkg::OP_INIT));
    write_setup(clns_pkg::RST_FUNCTION_SET, clns_pkg::RST_DISPLAY_MODE,
                clns_pkg::RST_ENTRY_MODE);
    send_word(random_word(clns_pkg::OP_INIT));
    drain_strobes();
  endtask

  task automatic test_random_traffic();
    int sent;
    int next_setup;
    int pick;
    clns_pkg::in_word_t w;
    logic [2:0] slot;
    sent = 0;
    next_setup = 70;
    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        slot = 3'($urandom_range(0, 7));
        for (int r = 0; r < 8; r++) begin
          w = random_word(clns_pkg::OP_GLYPH_ROW);
          w.glyph_slot = slot;
          w.glyph_row = 3'(r);
          send_word(w);
        end
        sent += 8;
      end else if (pick < 17) begin
        send_word(random_word($urandom_range(0, 1) ? OP_UNDEF_LOW : OP_UNDEF_HIGH));
      end else if (pick < 24) begin
        send_word(random_word(clns_pkg::OP_INIT));
        sent++;
      end else begin
        send_word(random_word(3'($urandom_range(clns_pkg::OP_COMMAND,
                                                clns_pkg::OP_GLYPH_ROW))));
        sent++;
      end
      if (sent >= next_setup) begin
        next_setup += 70;
        if ($urandom_range(0, 1) == 1) begin
          write_setup(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end else begin
          drain_strobes();
        end
      end
    end
    drain_strobes();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_setup();
    test_directed_requests();
    test_setup_registers();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_strobes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
